FILE: hdl/vgmcsp_pkg.sv
// ----------------------------------------------------------------------------
// vgmcsp_pkg
// Shared types, opcodes and widths for the command stream player.
// ----------------------------------------------------------------------------
package vgmcsp_pkg;

   // widths
   localparam int OFFSET_BITS   = 24;
   localparam int FRACTION_BITS = 12;
   localparam int LENGTH_W      = 24;
   localparam int SAMPLES_W     = 32;
   localparam int FACTOR_W      = 22;
   localparam int STAMP_W       = 42;
   localparam int COUNTDOWN_W   = SAMPLES_W + 1;
   localparam int CMP_W         = (OFFSET_BITS > LENGTH_W) ? OFFSET_BITS : LENGTH_W;
   localparam int PROD_W        = SAMPLES_W + FACTOR_W;
   localparam int SUM_W         = PROD_W + FRACTION_BITS;

   // queue between parser and stamp pipeline
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // stream opcodes
   localparam logic [7:0] OPC_END        = 8'h66;
   localparam logic [7:0] OPC_NTSC_WAIT  = 8'h62;
   localparam logic [7:0] OPC_PAL_WAIT   = 8'h63;
   localparam logic [7:0] OPC_STEREO     = 8'h4f;
   localparam logic [7:0] OPC_PSG        = 8'h50;
   localparam logic [7:0] OPC_WAIT16     = 8'h61;
   localparam logic [7:0] OPC_GROUP_MASK = 8'hf0;
   localparam logic [7:0] OPC_GROUP_2B   = 8'h50;

   localparam logic [15:0] NTSC_SAMPLES = 16'd735;
   localparam logic [15:0] PAL_SAMPLES  = 16'd882;

   // register indexes
   localparam logic [1:0] CSR_DATA_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_LOOP_START   = 2'd1;
   localparam logic [1:0] CSR_LOOP_SAMPLES = 2'd2;
   localparam logic [1:0] CSR_CLOCK_FACTOR = 2'd3;

   typedef enum logic [2:0] {
      EV_PSG_WRITE    = 3'd0,
      EV_STEREO_WRITE = 3'd1,
      EV_WAIT         = 3'd2,
      EV_LOOP_RESTART = 3'd3,
      EV_TRACK_END    = 3'd4,
      EV_BAD_COMMAND  = 3'd5
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_COMMAND  = 2'd0,
      PH_OPERAND1 = 2'd1,
      PH_OPERAND2 = 2'd2
   } parse_phase_type;

   typedef enum logic [2:0] {
      OP_END,
      OP_FRAME_WAIT,
      OP_WRITE,
      OP_TWO_OPERAND,
      OP_BAD
   } op_class_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [7:0]           write_value;
      logic [15:0]          wait_samples;
      logic [SAMPLES_W-1:0] sample_time;
      logic [STAMP_W-1:0]   clock_stamp;
      logic                 restart_at_loop;
      logic                 track_ended;
   } rsp_payload_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [7:0]           write_value;
      logic [15:0]          wait_samples;
      logic [SAMPLES_W-1:0] sample_time;
      logic                 restart_at_loop;
      logic                 track_ended;
      logic                 stamp_en;
   } queue_entry_type;

   typedef struct packed {
      logic [LENGTH_W-1:0]  data_length;
      logic [LENGTH_W-1:0]  loop_start_offset;
      logic [SAMPLES_W-1:0] loop_length_samples;
   } front_cfg_type;

   // sort a command byte into its handling group
   function automatic op_class_type classify(input logic [7:0] b);
      op_class_type c;
      if (b == OPC_END) begin
         c = OP_END;
      end else if (b inside {OPC_NTSC_WAIT, OPC_PAL_WAIT}) begin
         c = OP_FRAME_WAIT;
      end else if (b inside {OPC_STEREO, OPC_PSG}) begin
         c = OP_WRITE;
      end else if (b == OPC_WAIT16 || (b & OPC_GROUP_MASK) == OPC_GROUP_2B) begin
         c = OP_TWO_OPERAND;
      end else begin
         c = OP_BAD;
      end
      return c;
   endfunction

endpackage

FILE: hdl/vgm_command_stream_player_unit.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_player_unit
// VGM 1.01 command stream parser with PSG write time stamping.
// ----------------------------------------------------------------------------
// Feed one stream byte per item; a byte is taken every cycle while the event
// queue has room, since the parser updates its offset, phase, sample time and
// loop countdown as it takes each byte. Each byte yields zero or one event.
// An event passes from the parser through the queue, then through two stages
// in the stamper (the 32x22 multiply of sample time by clock factor, then
// rounding and the result register) before it appears on the rsp channel. A
// four-entry queue between parser and stamper absorbs output stalls. Write the
// registers only while no events are in flight.
// ----------------------------------------------------------------------------
module vgm_command_stream_player_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  vgmcsp_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output vgmcsp_pkg::rsp_payload_type rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);

   logic [vgmcsp_pkg::LENGTH_W-1:0]  data_length_ff;
   logic [vgmcsp_pkg::LENGTH_W-1:0]  loop_origin_ff;
   logic [vgmcsp_pkg::SAMPLES_W-1:0] loop_samples_ff;
   logic [vgmcsp_pkg::FACTOR_W-1:0]  clock_factor_ff;

   vgmcsp_pkg::front_cfg_type   front_cfg;
   vgmcsp_pkg::queue_entry_type push_data;
   vgmcsp_pkg::queue_entry_type pop_data;
   logic                        push_valid;
   logic                        queue_full;
   logic                        pop_valid;
   logic                        pop_ready;
   logic                        accept;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         data_length_ff  <= '0;
         loop_origin_ff  <= '0;
         loop_samples_ff <= '0;
         clock_factor_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            vgmcsp_pkg::CSR_DATA_LENGTH:  data_length_ff  <= csr_wdata[vgmcsp_pkg::LENGTH_W-1:0];
            vgmcsp_pkg::CSR_LOOP_START:   loop_origin_ff  <= csr_wdata[vgmcsp_pkg::LENGTH_W-1:0];
            vgmcsp_pkg::CSR_LOOP_SAMPLES: loop_samples_ff <= csr_wdata;
            vgmcsp_pkg::CSR_CLOCK_FACTOR: clock_factor_ff <= csr_wdata[vgmcsp_pkg::FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign front_cfg.data_length         = data_length_ff;
   assign front_cfg.loop_start_offset   = loop_origin_ff;
   assign front_cfg.loop_length_samples = loop_samples_ff;

   vgmcsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (front_cfg),
      .accept      (accept),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   vgmcsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vgmcsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .clock_factor (clock_factor_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

FILE: hdl/vgmcsp_queue.sv
// ----------------------------------------------------------------------------
// vgmcsp_queue
// Small register FIFO that holds decoded events between parser and stamper.
// ----------------------------------------------------------------------------
module vgmcsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  vgmcsp_pkg::queue_entry_type push_data,
   output logic                        full,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output vgmcsp_pkg::queue_entry_type pop_data
);

   vgmcsp_pkg::queue_entry_type entry_ff [vgmcsp_pkg::QUEUE_DEPTH];

   logic [vgmcsp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vgmcsp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vgmcsp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                               do_push, do_pop;

   assign full      = (count_ff == vgmcsp_pkg::QUEUE_CNT_W'(vgmcsp_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/vgmcsp_front.sv
// ----------------------------------------------------------------------------
// vgmcsp_front
// Stream parser: takes one byte per cycle while the queue has room, tracks
// offset, phase, sample time and loop countdown, and emits decoded events
// into the queue.
module vgmcsp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  vgmcsp_pkg::front_cfg_type   cfg,
   input  logic                        accept,
   input  vgmcsp_pkg::req_payload_type req_payload,
   output logic                        push_valid,
   output vgmcsp_pkg::queue_entry_type push_data
);

   localparam int OB = vgmcsp_pkg::OFFSET_BITS;
   localparam int CW = vgmcsp_pkg::CMP_W;
   localparam int DW = vgmcsp_pkg::COUNTDOWN_W;
   localparam int SW = vgmcsp_pkg::SAMPLES_W;

   logic [OB-1:0]                bo_ff, bo_in;
   vgmcsp_pkg::parse_phase_type  phase_ff, phase_in;
   logic [7:0]                   opcode_ff, opcode_in;
   logic [7:0]                   low_wait_ff, low_wait_in;
   logic [SW-1:0]                samples_ff, samples_in;
   logic [DW-1:0]                countdown_ff, countdown_in;
   logic                         finished_ff, finished_in;

   logic [OB-1:0]                bo_inc;
   logic [OB-1:0]                loop_point;
   logic [CW-1:0]                dl_wide;
   logic [CW-1:0]                ls_wide;
   logic [CW:0]                  bo_inc_plus;
   logic [7:0]                   b;
   vgmcsp_pkg::op_class_type     op_class;
   vgmcsp_pkg::event_kind_type   kind;
   logic                         have_kind;
   logic                         live;
   logic                         cut;
   logic                         ended;
   logic                         restart;
   logic                         stamp_en;
   logic [7:0]                   write_value;
   logic [15:0]                  wait_len;
   logic                         wait_do;

   assign b           = req_payload.data_byte;
   assign op_class    = vgmcsp_pkg::classify(b);
   assign bo_inc      = bo_ff + OB'(1);
   assign loop_point  = OB'(cfg.loop_start_offset);
   assign dl_wide     = CW'(cfg.data_length);
   assign ls_wide     = CW'(cfg.loop_start_offset);
   assign bo_inc_plus = (CW + 1)'(bo_inc) + (CW + 1)'(1);

   // parse one byte: next state and decoded event
   always_comb begin
      bo_in        = bo_ff;
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      low_wait_in  = low_wait_ff;
      samples_in   = samples_ff;
      countdown_in = countdown_ff;
      finished_in  = finished_ff;
      kind         = vgmcsp_pkg::EV_TRACK_END;
      have_kind    = 1'b0;
      live         = 1'b0;
      cut          = 1'b0;
      ended        = 1'b0;
      restart      = 1'b0;
      stamp_en     = 1'b0;
      write_value  = '0;
      wait_len     = '0;
      wait_do      = 1'b0;

      if (accept) begin
         if (req_payload.command) begin
            // start track: clear all position and time state
            bo_in        = '0;
            phase_in     = vgmcsp_pkg::PH_COMMAND;
            opcode_in    = '0;
            low_wait_in  = '0;
            samples_in   = '0;
            countdown_in = '0;
            finished_in  = 1'b0;
         end else if (!finished_ff) begin
            if (phase_ff == vgmcsp_pkg::PH_COMMAND) begin
               if (CW'(bo_ff) < dl_wide) begin
                  live = 1'b1;
                  // arm the loop countdown at the loop point
                  if (countdown_ff == '0 && CW'(bo_ff) >= ls_wide) begin
                     countdown_in = DW'(cfg.loop_length_samples);
                  end
                  bo_in = bo_inc;
                  case (op_class)
                     vgmcsp_pkg::OP_END: begin
                        if (cfg.loop_length_samples != '0) begin
                           bo_in        = loop_point;
                           countdown_in = DW'(cfg.loop_length_samples);
                           kind         = vgmcsp_pkg::EV_LOOP_RESTART;
                           have_kind    = 1'b1;
                           restart      = 1'b1;
                        end else begin
                           kind      = vgmcsp_pkg::EV_TRACK_END;
                           have_kind = 1'b1;
                           ended     = 1'b1;
                        end
                     end
                     vgmcsp_pkg::OP_FRAME_WAIT: begin
                        wait_do   = 1'b1;
                        wait_len  = (b == vgmcsp_pkg::OPC_NTSC_WAIT) ?
                                    vgmcsp_pkg::NTSC_SAMPLES : vgmcsp_pkg::PAL_SAMPLES;
                        kind      = vgmcsp_pkg::EV_WAIT;
                        have_kind = 1'b1;
                     end
                     vgmcsp_pkg::OP_WRITE: begin
                        if (CW'(bo_inc) >= dl_wide) begin
                           cut = 1'b1;
                        end else begin
                           opcode_in = b;
                           phase_in  = vgmcsp_pkg::PH_OPERAND1;
                        end
                     end
                     vgmcsp_pkg::OP_TWO_OPERAND: begin
                        if (bo_inc_plus >= (CW + 1)'(dl_wide)) begin
                           cut = 1'b1;
                        end else begin
                           opcode_in = b;
                           phase_in  = vgmcsp_pkg::PH_OPERAND1;
                        end
                     end
                     default: begin
                        kind      = vgmcsp_pkg::EV_BAD_COMMAND;
                        have_kind = 1'b1;
                     end
                  endcase
               end
            end else begin
               live  = 1'b1;
               bo_in = bo_inc;
               if (opcode_ff == vgmcsp_pkg::OPC_PSG || opcode_ff == vgmcsp_pkg::OPC_STEREO) begin
                  kind        = (opcode_ff == vgmcsp_pkg::OPC_PSG) ?
                                vgmcsp_pkg::EV_PSG_WRITE : vgmcsp_pkg::EV_STEREO_WRITE;
                  have_kind   = 1'b1;
                  write_value = b;
                  stamp_en    = 1'b1;
                  phase_in    = vgmcsp_pkg::PH_COMMAND;
               end else if (opcode_ff == vgmcsp_pkg::OPC_WAIT16) begin
                  if (phase_ff == vgmcsp_pkg::PH_OPERAND1) begin
                     low_wait_in = b;
                     phase_in    = vgmcsp_pkg::PH_OPERAND2;
                  end else begin
                     wait_len  = {b, low_wait_ff};
                     wait_do   = 1'b1;
                     kind      = vgmcsp_pkg::EV_WAIT;
                     have_kind = 1'b1;
                     phase_in  = vgmcsp_pkg::PH_COMMAND;
                  end
               end else begin
                  // skip the operands of another chip's command
                  phase_in = (phase_ff == vgmcsp_pkg::PH_OPERAND1) ?
                             vgmcsp_pkg::PH_OPERAND2 : vgmcsp_pkg::PH_COMMAND;
               end
            end

            // advance time; restart at the loop point when the countdown runs out
            if (wait_do) begin
               samples_in = samples_ff + SW'(wait_len);
               if (countdown_in != '0) begin
                  if (DW'(wait_len) >= countdown_in) begin
                     countdown_in = '0;
                     bo_in        = loop_point;
                     restart      = 1'b1;
                  end else begin
                     countdown_in = countdown_in - DW'(wait_len);
                  end
               end
            end

            // end of data
            if (cut) begin
               kind      = vgmcsp_pkg::EV_TRACK_END;
               have_kind = 1'b1;
               ended     = 1'b1;
            end else if (live && phase_in == vgmcsp_pkg::PH_COMMAND &&
                         CW'(bo_in) >= dl_wide) begin
               ended = 1'b1;
            end
            if (ended) begin
               finished_in = 1'b1;
               if (!have_kind) begin
                  kind      = vgmcsp_pkg::EV_TRACK_END;
                  have_kind = 1'b1;
               end
            end
         end
      end
   end

   assign push_valid                = have_kind;
   assign push_data.event_kind      = kind;
   assign push_data.write_value     = write_value;
   assign push_data.wait_samples    = wait_len;
   assign push_data.sample_time     = samples_ff;
   assign push_data.restart_at_loop = restart;
   assign push_data.track_ended     = ended;
   assign push_data.stamp_en        = stamp_en;

   // hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         bo_ff        <= '0;
         phase_ff     <= vgmcsp_pkg::PH_COMMAND;
         opcode_ff    <= '0;
         low_wait_ff  <= '0;
         samples_ff   <= '0;
         countdown_ff <= '0;
         finished_ff  <= 1'b0;
      end else begin
         bo_ff        <= bo_in;
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         low_wait_ff  <= low_wait_in;
         samples_ff   <= samples_in;
         countdown_ff <= countdown_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

FILE: hdl/vgmcsp_back.sv
// ----------------------------------------------------------------------------
// vgmcsp_back
// Stamp pipeline: multiplies write events' sample time by the clock factor
// (other events get a zero stamp), rounds, and drives the result register.
// ----------------------------------------------------------------------------
module vgmcsp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [vgmcsp_pkg::FACTOR_W-1:0]       clock_factor,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  vgmcsp_pkg::queue_entry_type           pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output vgmcsp_pkg::rsp_payload_type           rsp_payload
);

   localparam int PW = vgmcsp_pkg::PROD_W;
   localparam int SM = vgmcsp_pkg::SUM_W;
   localparam logic [SM-1:0] ROUND_HALF = SM'(1) << (vgmcsp_pkg::FRACTION_BITS - 1);

   logic                        a_valid_ff, a_valid_in;
   vgmcsp_pkg::queue_entry_type a_entry_ff;
   logic [PW-1:0]               a_prod_ff, a_prod_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   vgmcsp_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                        b_ready;
   logic                        a_move;
   logic [SM-1:0]               rounded;

   assign b_ready   = !rsp_valid_ff || rsp_ready;
   assign a_move    = a_valid_ff && b_ready;
   assign pop_ready = !a_valid_ff || b_ready;

   // multiply stage
   assign a_prod_in  = pop_data.stamp_en ?
                       PW'(pop_data.sample_time) * PW'(clock_factor) : '0;
   assign a_valid_in = pop_ready ? pop_valid : a_valid_ff;

   // round and shift into the result register
   assign rounded = SM'(a_prod_ff) + ROUND_HALF;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (b_ready) begin
         rsp_valid_in                   = a_valid_ff;
         rsp_payload_in.event_kind      = a_entry_ff.event_kind;
         rsp_payload_in.write_value     = a_entry_ff.write_value;
         rsp_payload_in.wait_samples    = a_entry_ff.wait_samples;
         rsp_payload_in.sample_time     = a_entry_ff.sample_time;
         rsp_payload_in.clock_stamp     =
            rounded[vgmcsp_pkg::FRACTION_BITS +: vgmcsp_pkg::STAMP_W];
         rsp_payload_in.restart_at_loop = a_entry_ff.restart_at_loop;
         rsp_payload_in.track_ended     = a_entry_ff.track_ended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop_ready) begin
         a_entry_ff <= pop_data;
         a_prod_ff  <= a_prod_in;
      end
      if (a_move) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: bench/tb_vgm_command_stream_player_unit.sv
// ----------------------------------------------------------------------------
// tb_vgm_command_stream_player_unit
// Self-checking bench for the VGM command stream player.
// ----------------------------------------------------------------------------
// A feeder plays short generated tracks into the player byte by byte. It
// follows the predicted byte offset, so loop restarts send it back to the
// loop point as a real stream fetcher would. A scoreboard predicts every
// event from the bytes the player accepts and checks the rsp channel in order.
// Directed tracks come first. Random tracks follow, each under new register
// settings, with noise bytes, random idle on both channels and one long
// output stall.
// ----------------------------------------------------------------------------

class event_scoreboard;
   localparam int LENGTH_W      = vgmcsp_pkg::LENGTH_W;
   localparam int SAMPLES_W     = vgmcsp_pkg::SAMPLES_W;
   localparam int FACTOR_W      = vgmcsp_pkg::FACTOR_W;
   localparam int OFFSET_BITS   = vgmcsp_pkg::OFFSET_BITS;
   localparam int COUNTDOWN_W   = vgmcsp_pkg::COUNTDOWN_W;
   localparam int STAMP_W       = vgmcsp_pkg::STAMP_W;
   localparam int FRACTION_BITS = vgmcsp_pkg::FRACTION_BITS;

   // register copies
   logic [LENGTH_W-1:0]    data_length;
   logic [LENGTH_W-1:0]    loop_origin;
   logic [SAMPLES_W-1:0]   loop_samples;
   logic [FACTOR_W-1:0]    clock_factor;
   // parser state
   logic [OFFSET_BITS-1:0]      byte_offset;
   vgmcsp_pkg::parse_phase_type phase;
   logic [7:0]                  opcode;
   logic [7:0]                  wait_low;
   logic [SAMPLES_W-1:0]        samples;
   logic [COUNTDOWN_W-1:0]      countdown;
   bit                          finished;
   // expected events, oldest first
   vgmcsp_pkg::rsp_payload_type pending_events[$];
   int                          failures;
   int                          events_checked;
   int                          kind_count[6];

   function new();
      data_length  = '0;
      loop_origin  = '0;
      loop_samples = '0;
      clock_factor = '0;
      failures     = 0;
      events_checked = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      restart_track();
   endfunction

   function void restart_track();
      byte_offset = '0;
      phase       = vgmcsp_pkg::PH_COMMAND;
      opcode      = '0;
      wait_low    = '0;
      samples     = '0;
      countdown   = '0;
      finished    = 1'b0;
   endfunction

   function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
         vgmcsp_pkg::CSR_DATA_LENGTH:  data_length  = value[LENGTH_W-1:0];
         vgmcsp_pkg::CSR_LOOP_START:   loop_origin  = value[LENGTH_W-1:0];
         vgmcsp_pkg::CSR_LOOP_SAMPLES: loop_samples = value[SAMPLES_W-1:0];
         vgmcsp_pkg::CSR_CLOCK_FACTOR: clock_factor = value[FACTOR_W-1:0];
         default: ;
      endcase
   endfunction

   // chip clock time: sample time times factor, rounded, fraction dropped
   function logic [STAMP_W-1:0] clock_time_of(logic [SAMPLES_W-1:0] t);
      logic [63:0] p;
      p = 64'(t) * 64'(clock_factor) + (64'd1 << (FRACTION_BITS - 1));
      return p[FRACTION_BITS +: STAMP_W];
   endfunction

   // advance time by a wait; report whether the loop countdown ran out
   function bit pass_samples(logic [15:0] w);
      samples = samples + SAMPLES_W'(w);
      if (countdown != 0) begin
         if (COUNTDOWN_W'(w) >= countdown) begin
            countdown   = '0;
            byte_offset = loop_origin;
            return 1'b1;
         end
         countdown = countdown - COUNTDOWN_W'(w);
      end
      return 1'b0;
   endfunction

   // predict the event of one accepted item; return 0 if the item is ignored
   function bit note_byte(vgmcsp_pkg::req_payload_type item);
      vgmcsp_pkg::rsp_payload_type ev;
      logic [7:0]                  b;
      logic [LENGTH_W:0]           room;
      bit                          have;
      bit                          cut;
      b    = item.data_byte;
      ev   = '0;
      have = 1'b0;
      cut  = 1'b0;
      ev.sample_time = samples;
      if (item.command) begin
         restart_track();
         return 1'b1;
      end
      if (finished) return 1'b0;
      if (phase == vgmcsp_pkg::PH_COMMAND) begin
         if (byte_offset >= data_length) return 1'b0;
         // arm the loop countdown once the loop point is reached
         if (countdown == 0 && byte_offset >= loop_origin) begin
            countdown = COUNTDOWN_W'(loop_samples);
         end
         byte_offset++;
         room = (byte_offset <= data_length) ? data_length - byte_offset : '0;
         if (b == vgmcsp_pkg::OPC_END) begin
            have = 1'b1;
            if (loop_samples != 0) begin
               byte_offset        = loop_origin;
               countdown          = COUNTDOWN_W'(loop_samples);
               ev.event_kind      = vgmcsp_pkg::EV_LOOP_RESTART;
               ev.restart_at_loop = 1'b1;
            end else begin
               ev.event_kind  = vgmcsp_pkg::EV_TRACK_END;
               ev.track_ended = 1'b1;
            end
         end else if (b == vgmcsp_pkg::OPC_NTSC_WAIT || b == vgmcsp_pkg::OPC_PAL_WAIT) begin
            have               = 1'b1;
            ev.event_kind      = vgmcsp_pkg::EV_WAIT;
            ev.wait_samples    = (b == vgmcsp_pkg::OPC_NTSC_WAIT) ?
                                 vgmcsp_pkg::NTSC_SAMPLES : vgmcsp_pkg::PAL_SAMPLES;
            ev.restart_at_loop = pass_samples(ev.wait_samples);
         end else if (b == vgmcsp_pkg::OPC_STEREO || b == vgmcsp_pkg::OPC_PSG) begin
            if (room < 1) begin
               cut = 1'b1;
            end else begin
               opcode = b;
               phase  = vgmcsp_pkg::PH_OPERAND1;
            end
         end else if (b == vgmcsp_pkg::OPC_WAIT16 ||
                      (b & vgmcsp_pkg::OPC_GROUP_MASK) == vgmcsp_pkg::OPC_GROUP_2B) begin
            if (room < 2) begin
               cut = 1'b1;
            end else begin
               opcode = b;
               phase  = vgmcsp_pkg::PH_OPERAND1;
            end
         end else begin
            have          = 1'b1;
            ev.event_kind = vgmcsp_pkg::EV_BAD_COMMAND;
         end
      end else begin
         byte_offset++;
         if (opcode == vgmcsp_pkg::OPC_STEREO || opcode == vgmcsp_pkg::OPC_PSG) begin
            have           = 1'b1;
            ev.event_kind  = (opcode == vgmcsp_pkg::OPC_PSG) ?
                             vgmcsp_pkg::EV_PSG_WRITE : vgmcsp_pkg::EV_STEREO_WRITE;
            ev.write_value = b;
            ev.clock_stamp = clock_time_of(samples);
            phase          = vgmcsp_pkg::PH_COMMAND;
         end else if (opcode == vgmcsp_pkg::OPC_WAIT16) begin
            if (phase == vgmcsp_pkg::PH_OPERAND1) begin
               wait_low = b;
               phase    = vgmcsp_pkg::PH_OPERAND2;
            end else begin
               have               = 1'b1;
               ev.event_kind      = vgmcsp_pkg::EV_WAIT;
               ev.wait_samples    = {b, wait_low};
               phase              = vgmcsp_pkg::PH_COMMAND;
               ev.restart_at_loop = pass_samples(ev.wait_samples);
            end
         end else begin
            // other chips: skip both operands
            phase = (phase == vgmcsp_pkg::PH_OPERAND1) ?
                    vgmcsp_pkg::PH_OPERAND2 : vgmcsp_pkg::PH_COMMAND;
         end
      end
      // drop a cut-off command; finish at the end of the data
      if (cut) begin
         have           = 1'b1;
         ev.event_kind  = vgmcsp_pkg::EV_TRACK_END;
         ev.track_ended = 1'b1;
      end else if (phase == vgmcsp_pkg::PH_COMMAND && byte_offset >= data_length) begin
         ev.track_ended = 1'b1;
      end
      if (ev.track_ended) begin
         finished = 1'b1;
         if (!have) begin
            have          = 1'b1;
            ev.event_kind = vgmcsp_pkg::EV_TRACK_END;
         end
      end
      if (have) pending_events.push_back(ev);
      return 1'b1;
   endfunction

   function bit field_matches(string name, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // compare one event with the oldest expectation
   function void check_event(vgmcsp_pkg::rsp_payload_type got);
      vgmcsp_pkg::rsp_payload_type want;
      bit                          ok;
      if (pending_events.size() == 0) begin
         $error("unexpected event: kind %0d at sample time %0d", got.event_kind,
                got.sample_time);
         failures++;
         return;
      end
      want = pending_events.pop_front();
      ok = field_matches("event_kind", want.event_kind, got.event_kind);
      ok &= field_matches("write_value", want.write_value, got.write_value);
      ok &= field_matches("wait_samples", want.wait_samples, got.wait_samples);
      ok &= field_matches("sample_time", want.sample_time, got.sample_time);
      ok &= field_matches("clock_stamp", want.clock_stamp, got.clock_stamp);
      ok &= field_matches("restart_at_loop", want.restart_at_loop, got.restart_at_loop);
      ok &= field_matches("track_ended", want.track_ended, got.track_ended);
      if (!ok) failures++;
      events_checked++;
      kind_count[int'(want.event_kind)]++;
   endfunction
endclass

module tb_vgm_command_stream_player_unit;

   localparam int SETTLE_CYCLES     = 12;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int RUN_ITEMS         = 820;
   localparam int LENGTH_W          = vgmcsp_pkg::LENGTH_W;
   localparam int SAMPLES_W         = vgmcsp_pkg::SAMPLES_W;
   localparam int FACTOR_W          = vgmcsp_pkg::FACTOR_W;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   vgmcsp_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   vgmcsp_pkg::rsp_payload_type rsp_payload;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [1:0]                  csr_index = '0;
   logic [31:0]                 csr_wdata = '0;

   event_scoreboard sb = new();

   logic [7:0] track_image[$];
   int         command_starts[$];
   int         stream_items = 0;
   int         settings_loaded = 0;
   bit         long_stall_request = 1'b0;

   vgm_command_stream_player_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short idle, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [7:0] bad_opcode();
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while (b == vgmcsp_pkg::OPC_END || b == vgmcsp_pkg::OPC_NTSC_WAIT ||
                 b == vgmcsp_pkg::OPC_PAL_WAIT || b == vgmcsp_pkg::OPC_STEREO ||
                 b == vgmcsp_pkg::OPC_WAIT16 ||
                 (b & vgmcsp_pkg::OPC_GROUP_MASK) == vgmcsp_pkg::OPC_GROUP_2B);
      return b;
   endfunction

   // bytes past the image read as random noise
   function automatic logic [7:0] image_byte(int unsigned pos);
      if (pos < track_image.size()) return track_image[pos];
      return 8'($urandom);
   endfunction

   // fill the image with whole commands until it holds at least target bytes
   function automatic void build_track(int target);
      int          pick;
      logic [15:0] span;
      track_image.delete();
      command_starts.delete();
      while (track_image.size() < target) begin
         command_starts.push_back(track_image.size());
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            track_image.push_back(vgmcsp_pkg::OPC_PSG);
            track_image.push_back(8'($urandom));
         end else if (pick < 42) begin
            track_image.push_back(vgmcsp_pkg::OPC_STEREO);
            track_image.push_back(8'($urandom));
         end else if (pick < 57) begin
            case ($urandom_range(0, 7))
               0: span = 16'h0000;
               1: span = 16'hffff;
               default: span = 16'($urandom);
            endcase
            track_image.push_back(vgmcsp_pkg::OPC_WAIT16);
            track_image.push_back(span[7:0]);
            track_image.push_back(span[15:8]);
         end else if (pick < 72) begin
            track_image.push_back($urandom_range(0, 1) ? vgmcsp_pkg::OPC_NTSC_WAIT
                                                       : vgmcsp_pkg::OPC_PAL_WAIT);
         end else if (pick < 84) begin
            track_image.push_back(8'h51 + 8'($urandom_range(0, 14)));
            track_image.push_back(8'($urandom));
            track_image.push_back(8'($urandom));
         end else if (pick < 96) begin
            track_image.push_back(bad_opcode());
         end else begin
            track_image.push_back(vgmcsp_pkg::OPC_END);
         end
      end
   endfunction

   // offer one item after a gap, or after all pending events have come out
   task automatic send_item(vgmcsp_pkg::req_payload_type item, int gap,
                            bit drain_first = 1'b0);
      if (drain_first) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (sb.pending_events.size() != 0);
      end else if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (sb.note_byte(item)) stream_items++;
   endtask

   // hold the input until the player has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, value);
   endtask

   // write all registers; junk in the unused upper bits must be dropped
   task automatic load_settings(logic [LENGTH_W-1:0] length, logic [LENGTH_W-1:0] start,
                                logic [SAMPLES_W-1:0] span, logic [FACTOR_W-1:0] factor);
      write_csr(vgmcsp_pkg::CSR_DATA_LENGTH, {8'($urandom), length});
      write_csr(vgmcsp_pkg::CSR_LOOP_START, {8'($urandom), start});
      write_csr(vgmcsp_pkg::CSR_LOOP_SAMPLES, span);
      write_csr(vgmcsp_pkg::CSR_CLOCK_FACTOR, {10'($urandom), factor});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // start the track and feed bytes from the offset the player is at
   task automatic play_track(int budget, bit noisy);
      vgmcsp_pkg::req_payload_type item;
      int                          sent;
      int                          pick;
      item.command   = 1'b1;
      item.data_byte = 8'($urandom);
      send_item(item, idle_length());
      sent = 0;
      while (sent < budget && !sb.finished && sb.byte_offset < sb.data_length) begin
         item.command   = 1'b0;
         item.data_byte = image_byte(sb.byte_offset);
         if (noisy) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               item.data_byte = 8'($urandom);
            end else if (pick < 5) begin
               item.command = 1'b1;
            end
         end
         send_item(item, idle_length(), noisy && $urandom_range(0, 39) == 0);
         sent++;
      end
      // a byte past the end goes unanswered
      if (!noisy || $urandom_range(0, 3) == 0) begin
         item.command   = 1'b0;
         item.data_byte = 8'($urandom);
         send_item(item, idle_length());
      end
   endtask

   // check every event the player hands over
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_event(rsp_payload);
   end

   // pace the result side; serve one long stall on request
   initial begin : response_pacing
      int hold;
      forever begin
         if (long_stall_request) begin
            rsp_ready <= 1'b0;
            for (hold = 0; hold < LONG_STALL_CYCLES; hold++) @(posedge clock);
            long_stall_request = 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
            do begin
               @(posedge clock);
               hold--;
            end while (hold > 0 && !long_stall_request);
            if (!long_stall_request) begin
               hold = idle_length();
               if (hold > 0) begin
                  rsp_ready <= 1'b0;
                  repeat (hold) @(posedge clock);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [LENGTH_W-1:0]  length;
      logic [LENGTH_W-1:0]  start;
      logic [SAMPLES_W-1:0] span;
      logic [FACTOR_W-1:0]  factor;
      int                   target;
      int                   pick;
      int                   track_count;
      bit                   pressure;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every opcode at least once, writes at zero and full scale, bad opcodes, end marker
      track_image = '{vgmcsp_pkg::OPC_PSG, 8'h00, vgmcsp_pkg::OPC_STEREO, 8'hff,
                      vgmcsp_pkg::OPC_NTSC_WAIT, vgmcsp_pkg::OPC_PAL_WAIT,
                      vgmcsp_pkg::OPC_WAIT16, 8'hff, 8'hff, vgmcsp_pkg::OPC_PSG, 8'h5a,
                      vgmcsp_pkg::OPC_STEREO, 8'ha5, 8'h5f, 8'h01, 8'h02, 8'h00, 8'hff,
                      vgmcsp_pkg::OPC_END};
      load_settings(24'd19, 24'd19, '0, '1);
      play_track(64, 1'b0);
      // a wait cut off by the end of the data
      settle();
      track_image = '{vgmcsp_pkg::OPC_WAIT16, 8'h34};
      load_settings(24'd2, '0, '1, '0);
      play_track(64, 1'b0);
      // empty stream: every byte is ignored
      settle();
      load_settings('0, '1, 32'd1, 22'd1);
      play_track(64, 1'b0);

      track_count = 0;
      while (stream_items < RUN_ITEMS) begin
         track_count++;
         pressure = (track_count == 3);
         target = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 64);
         build_track(target);
         pick = $urandom_range(0, 99);
         if (pressure || pick < 45) begin
            track_image.push_back(vgmcsp_pkg::OPC_END);
            length = LENGTH_W'(track_image.size());
         end else if (pick < 70) begin
            length = LENGTH_W'(track_image.size());
         end else if (pick < 95) begin
            length = LENGTH_W'(target);
         end else begin
            length = '1;
         end
         pick = $urandom_range(0, 99);
         if (pressure || pick < 15) start = '0;
         else if (pick < 60) begin
            start = LENGTH_W'(command_starts[$urandom_range(0, command_starts.size() - 1)]);
         end
         else if (pick < 75) start = length;
         else if (pick < 85) start = '1;
         else start = 24'($urandom);
         pick = $urandom_range(0, 99);
         if (pressure || pick < 10) span = '1;
         else if (pick < 40) span = '0;
         else if (pick < 50) span = 32'd1;
         else if (pick < 75) span = $urandom_range(100, 3000);
         else span = $urandom;
         pick = $urandom_range(0, 9);
         factor = (pick == 0) ? '0 : (pick == 1) ? '1 : 22'($urandom);
         settle();
         load_settings(length, start, span, factor);
         // keep feeding while the output is held off so the input backs up
         if (pressure) long_stall_request = 1'b1;
         play_track(pressure ? 200 : $urandom_range(16, 160), !pressure);
      end

      settle();
      $display("covered %0d stream items under %0d register settings, %0d events checked",
               stream_items, settings_loaded, sb.events_checked);
      $display("events: %0d psg, %0d stereo, %0d wait, %0d loop, %0d end, %0d bad",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
               sb.kind_count[4], sb.kind_count[5]);
      if (sb.failures == 0 && sb.pending_events.size() == 0) begin
         $display("tb_vgm_command_stream_player_unit: PASS");
      end else begin
         $display("tb_vgm_command_stream_player_unit: FAIL");
      end
      $finish;
   end

   // bound the run in case the player hangs
   initial begin
      #5000000;
      $display("tb_vgm_command_stream_player_unit: FAIL");
      $finish;
   end

endmodule

FILE: vgm_command_stream_player_unit.f
hdl/vgmcsp_pkg.sv
hdl/vgmcsp_queue.sv
hdl/vgmcsp_front.sv
hdl/vgmcsp_back.sv
hdl/vgm_command_stream_player_unit.sv
bench/tb_vgm_command_stream_player_unit.sv
